### rtl/tape_byte_edge_run_encoder_defines.svh
// assertion macros shared by the checker
`ifndef TAPE_BYTE_EDGE_RUN_ENCODER_DEFINES_SVH
`define TAPE_BYTE_EDGE_RUN_ENCODER_DEFINES_SVH

// antecedent now, consequent in the next cycle, off while in reset
`define TBRE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbre check failed");

// consequent in the cycle after a reset cycle
`define TBRE_ASSERT_RESET(name, cons) \
  name: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("tbre reset check failed");

`endif

### rtl/tbre_pkg.sv
`timescale 1ns / 1ps

package tbre_pkg;

  // field widths
  localparam int unsigned W_OP    = 3;
  localparam int unsigned W_BYTE  = 8;
  localparam int unsigned W_LEVEL = 8;
  localparam int unsigned W_COUNT = 19;
  localparam int unsigned W_RATE  = 18;
  localparam int unsigned W_CFG   = 18;
  localparam int unsigned W_IDX   = 1;
  localparam int unsigned W_CYC   = 16;
  localparam int unsigned W_REM   = 20;
  localparam int unsigned W_STEP  = 10;

  // op codes
  localparam logic [W_OP-1:0] OP_BYTE      = 3'd0;
  localparam logic [W_OP-1:0] OP_MOTOR_ON  = 3'd1;
  localparam logic [W_OP-1:0] OP_MOTOR_OFF = 3'd2;
  localparam logic [W_OP-1:0] OP_DATA_GAP  = 3'd3;
  localparam logic [W_OP-1:0] OP_SYNC      = 3'd4;

  // configuration register indexes
  localparam logic [W_IDX-1:0] REG_RATE = 1'b0;
  localparam logic [W_IDX-1:0] REG_MODE = 1'b1;

  localparam logic [W_RATE-1:0]  RATE_RESET  = 18'd22050;
  localparam logic [W_LEVEL-1:0] LEVEL_RESET = 8'hFF;

  // rom routine timing pieces, in cpu cycles
  localparam int unsigned SHORT_LOOP = 'h2d;
  localparam int unsigned LONG_LOOP  = 'h32;
  localparam int unsigned FAST_A     = 269;
  localparam int unsigned FAST_B     = 564;
  localparam int unsigned BYTE_HEAD  = 4 + 2 + 7 + 4 + 2;
  localparam int unsigned BYTE_TAIL  = 5 + 6 + 3;
  localparam int unsigned BIT_LEAD   = 7 + 2 + 4 + 4;
  localparam int unsigned BIT_END    = 2 + 3;
  localparam int unsigned STD_MID    = 5 + 3 + 7 + SHORT_LOOP * 8 + 2 + 5 + 3 + 6 + 3;
  localparam int unsigned STD_ZERO   = 7 + LONG_LOOP * 8 + 2 + 5;
  localparam int unsigned STD_ONE    = 5 + 4 + 1 + 7 + (LONG_LOOP - 3) * 8 + 2 + 5;

  typedef logic [W_STEP-1:0] step_t;

  // cycles added between consecutive edges
  localparam step_t K_FIRST          = step_t'(BYTE_HEAD + BIT_LEAD);
  localparam step_t K_STD_SECOND     = step_t'(STD_MID + BIT_LEAD);
  localparam step_t K_STD_LEAD_ZERO  = step_t'(STD_MID + STD_ZERO + BIT_END + BIT_LEAD);
  localparam step_t K_STD_LEAD_ONE   = step_t'(STD_ONE + BIT_END + BIT_LEAD);
  localparam step_t K_STD_TAIL_ZERO  = step_t'(STD_MID + STD_ZERO + BIT_END + BYTE_TAIL);
  localparam step_t K_STD_TAIL_ONE   = step_t'(STD_ONE + BIT_END + BYTE_TAIL);
  localparam step_t K_FAST_SECOND    = step_t'(FAST_A);
  localparam step_t K_FAST_LEAD_ZERO = step_t'(FAST_A + FAST_B + BIT_END + BIT_LEAD);
  localparam step_t K_FAST_LEAD_ONE  = step_t'(FAST_B + BIT_END + BIT_LEAD);
  localparam step_t K_FAST_TAIL_ZERO = step_t'(FAST_A + FAST_B + BIT_END + BYTE_TAIL);
  localparam step_t K_FAST_TAIL_ONE  = step_t'(FAST_B + BIT_END + BYTE_TAIL);

  // divisor 998400 = 1024 * 975, the odd part by reciprocal multiply
  localparam longint unsigned FRAME_CYC   = 19968;
  localparam longint unsigned FRAME_US    = 20000;
  localparam longint unsigned SEC_US      = 1000000;
  localparam longint unsigned DIVISOR     = FRAME_CYC * SEC_US / FRAME_US;
  localparam int unsigned     DIV_SHIFT   = 10;
  localparam longint unsigned DIV_ODD_VAL = DIVISOR >> DIV_SHIFT;
  localparam int unsigned     ODD_W       = 10;
  localparam int unsigned     RECIP_SHIFT = 35;
  localparam int unsigned     RECIP_W     = 26;
  localparam logic [ODD_W-1:0]   DIV_ODD = ODD_W'(DIV_ODD_VAL);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_ODD_VAL);

  // datapath word widths
  localparam int unsigned W_T = W_CYC + W_RATE + 1;
  localparam int unsigned W_U = W_T - DIV_SHIFT;
  localparam int unsigned W_Q = W_U + RECIP_W - RECIP_SHIFT;
  localparam int unsigned W_R = ODD_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD,
    S_LEAD_WAIT,
    S_SECOND,
    S_SECOND_WAIT,
    S_GAP
  } ctl_state_t;

  typedef struct packed {
    logic            edge_start;
    step_t           step;
    logic            edge_last;
    step_t           tail;
    logic            gap_emit;
    logic [W_OP-1:0] gap_op;
    logic            sync_clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic edge_busy;
    logic out_free;
    logic fast_mode;
  } dp_sts_t;

endpackage

### rtl/tbre_ctrl.sv
`timescale 1ns / 1ps

module tbre_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [tbre_pkg::W_OP-1:0]   in_op,
  input  logic [tbre_pkg::W_BYTE-1:0] in_data_byte,
  output logic                      in_ready,
  output tbre_pkg::ctl_cmd_t        cmd,
  input  tbre_pkg::dp_sts_t         sts
);
  import tbre_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [W_BYTE-1:0] byte_r;
  logic [2:0]        bit_idx_r;
  logic              first_r;
  logic              prev_one_r;
  logic [W_OP-1:0]   gap_op_r;

  logic  accept;
  logic  bit_val;
  logic  bit_adv;
  step_t lead_step;
  step_t tail_step;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign bit_val  = byte_r[bit_idx_r];

  // move to the next bit once this bit's last edge has gone through
  assign bit_adv = (bit_idx_r != 3'd0) && !sts.edge_busy &&
                   (((state_r == S_LEAD_WAIT) && !bit_val) || (state_r == S_SECOND_WAIT));

  // step to the leading edge, and what is left over after the byte
  always_comb begin
    if (first_r) begin
      lead_step = K_FIRST;
    end else if (sts.fast_mode) begin
      lead_step = prev_one_r ? K_FAST_LEAD_ONE : K_FAST_LEAD_ZERO;
    end else begin
      lead_step = prev_one_r ? K_STD_LEAD_ONE : K_STD_LEAD_ZERO;
    end
    if (sts.fast_mode) begin
      tail_step = bit_val ? K_FAST_TAIL_ONE : K_FAST_TAIL_ZERO;
    end else begin
      tail_step = bit_val ? K_STD_TAIL_ONE : K_STD_TAIL_ZERO;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // byte and bit bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_idx_r  <= 3'd0;
      first_r    <= 1'b0;
      prev_one_r <= 1'b0;
    end else if (accept) begin
      bit_idx_r <= 3'd7;
      first_r   <= 1'b1;
    end else if (bit_adv) begin
      bit_idx_r  <= bit_idx_r - 3'd1;
      first_r    <= 1'b0;
      prev_one_r <= bit_val;
    end
  end

  // payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r   <= in_data_byte;
      gap_op_r <= in_op;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_BYTE:                              state_nxt = S_LEAD;
            OP_MOTOR_ON, OP_MOTOR_OFF, OP_DATA_GAP: state_nxt = S_GAP;
            default:                              state_nxt = S_IDLE;
          endcase
        end
      end
      S_LEAD: state_nxt = S_LEAD_WAIT;
      S_LEAD_WAIT: begin
        if (!sts.edge_busy) begin
          if (bit_val) begin
            state_nxt = S_SECOND;
          end else if (bit_idx_r == 3'd0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LEAD;
          end
        end
      end
      S_SECOND: state_nxt = S_SECOND_WAIT;
      S_SECOND_WAIT: begin
        if (!sts.edge_busy) begin
          state_nxt = (bit_idx_r == 3'd0) ? S_IDLE : S_LEAD;
        end
      end
      S_GAP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd        = '0;
    cmd.tail   = tail_step;
    cmd.gap_op = gap_op_r;
    case (state_r)
      S_IDLE: begin
        cmd.sync_clear = accept && (in_op == OP_SYNC);
      end
      S_LEAD: begin
        cmd.edge_start = 1'b1;
        cmd.step       = lead_step;
        cmd.edge_last  = (bit_idx_r == 3'd0) && !bit_val;
      end
      S_SECOND: begin
        cmd.edge_start = 1'b1;
        cmd.step       = sts.fast_mode ? K_FAST_SECOND : K_STD_SECOND;
        cmd.edge_last  = (bit_idx_r == 3'd0);
      end
      S_GAP: begin
        cmd.gap_emit = 1'b1;
      end
      default: begin
        cmd.edge_start = 1'b0;
      end
    endcase
  end

endmodule

### rtl/tbre_dp.sv
`timescale 1ns / 1ps

module tbre_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [tbre_pkg::W_IDX-1:0]   cfg_index,
  input  logic [tbre_pkg::W_CFG-1:0]   cfg_data,
  output logic                         cfg_ready,
  input  tbre_pkg::ctl_cmd_t           cmd,
  output tbre_pkg::dp_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tbre_pkg::W_LEVEL-1:0] out_level,
  output logic [tbre_pkg::W_COUNT-1:0] out_sample_count,
  output logic                         out_last
);
  import tbre_pkg::*;

  // configuration and timing state
  logic [W_RATE-1:0]  rate_r;
  logic               fast_r;
  logic [W_LEVEL-1:0] level_r;
  logic [W_CYC-1:0]   pend_r;
  logic [W_REM-1:0]   rem_r;

  // edge pipeline
  logic                 va_r, vb_r, vc_r, vd_r;
  logic                 last_r;
  logic [W_T-1:0]       t_r;
  logic [W_Q-1:0]       q0_b_r, q0_c_r;
  logic [W_U-1:0]       u_b_r;
  logic [DIV_SHIFT-1:0] low_b_r, low_c_r;
  logic [W_R-1:0]       r_c_r;

  // output register
  logic               out_valid_r;
  logic [W_LEVEL-1:0] out_level_r;
  logic [W_COUNT-1:0] out_count_r;
  logic               out_last_r;

  logic                     out_free;
  logic                     commit;
  logic [W_CYC-1:0]         cyc_a;
  logic [W_CYC+W_RATE-1:0]  mul_a;
  logic [W_T-1:0]           t_nxt;
  logic [W_U+RECIP_W-1:0]   mul_b;
  logic [W_Q+ODD_W-1:0]     mul_c;
  logic [W_U-1:0]           diff_c;
  logic                     fix_d;
  logic [W_Q-1:0]           q_d;
  logic [W_R-1:0]           r_d;
  logic [W_COUNT-1:0]       gap_count;

  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid_r || out_ready;
  assign commit        = vd_r && out_free;
  assign sts.edge_busy = va_r || vb_r || vc_r || vd_r;
  assign sts.out_free  = out_free;
  assign sts.fast_mode = fast_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      fast_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE: rate_r <= cfg_data[W_RATE-1:0];
        REG_MODE: fast_r <= cfg_data[0];
        default:  fast_r <= fast_r;
      endcase
    end
  end

  // stage a: cycles times rate plus carried remainder
  assign cyc_a = pend_r + W_CYC'(cmd.step);
  assign mul_a = cyc_a * rate_r;
  assign t_nxt = W_T'(mul_a) + W_T'(rem_r);

  // stage b: reciprocal estimate of the quotient by the odd factor
  assign mul_b = t_r[W_T-1:DIV_SHIFT] * RECIP;

  // stage c: partial remainder of the estimate, below twice the odd factor
  assign mul_c  = q0_b_r * DIV_ODD;
  assign diff_c = u_b_r - mul_c[W_U-1:0];

  // stage d: single correction step
  assign fix_d = (r_c_r >= W_R'(DIV_ODD));
  assign q_d   = q0_c_r + W_Q'(fix_d);
  assign r_d   = fix_d ? (r_c_r - W_R'(DIV_ODD)) : r_c_r;

  // pipeline valid bits, one edge in flight at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= cmd.edge_start;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r || (vd_r && !out_free);
    end
  end

  // pipeline data
  always_ff @(posedge clk) begin
    if (cmd.edge_start) begin
      t_r    <= t_nxt;
      last_r <= cmd.edge_last;
    end
    q0_b_r  <= mul_b[RECIP_SHIFT +: W_Q];
    u_b_r   <= t_r[W_T-1:DIV_SHIFT];
    low_b_r <= t_r[DIV_SHIFT-1:0];
    q0_c_r  <= q0_b_r;
    r_c_r   <= diff_c[W_R-1:0];
    low_c_r <= low_b_r;
  end

  // cycle count, remainder and level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      rem_r   <= '0;
      level_r <= LEVEL_RESET;
    end else begin
      if (cmd.sync_clear) begin
        pend_r <= '0;
        rem_r  <= '0;
      end else if (cmd.edge_start) begin
        pend_r <= cmd.edge_last ? W_CYC'(cmd.tail) : '0;
      end
      if (commit) begin
        rem_r   <= {r_d[ODD_W-1:0], low_c_r};
        level_r <= ~level_r;
      end
    end
  end

  // gap run lengths
  always_comb begin
    case (cmd.gap_op)
      OP_MOTOR_ON:  gap_count = W_COUNT'(rate_r);
      OP_MOTOR_OFF: gap_count = {rate_r, 1'b0};
      OP_DATA_GAP:  gap_count = W_COUNT'(rate_r >> 3);
      default:      gap_count = '0;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit || (cmd.gap_emit && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (commit) begin
      out_level_r <= level_r;
      out_count_r <= W_COUNT'(q_d);
      out_last_r  <= last_r;
    end else if (cmd.gap_emit && out_free) begin
      out_level_r <= level_r;
      out_count_r <= gap_count;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_sample_count = out_count_r;
  assign out_last         = out_last_r;

endmodule

### rtl/tape_byte_edge_run_encoder.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_op, in_data_byte
// out       output     out_valid / out_ready  out_level, out_sample_count, out_last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a data byte gives an edge run for each bit and one more for each one bit:
// each edge run goes through the four-stage divide pipeline before the next starts.
// gaps wait for a free output, sync and unused ops end on accept; in_ready is high
// only when idle. a full output register stalls the last stage until out_ready.
// synchronous active-low reset, no clearing pass; cfg_ready is always high.

module tape_byte_edge_run_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tbre_pkg::W_OP-1:0]    in_op,
  input  logic [tbre_pkg::W_BYTE-1:0]  in_data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tbre_pkg::W_LEVEL-1:0] out_level,
  output logic [tbre_pkg::W_COUNT-1:0] out_sample_count,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tbre_pkg::W_IDX-1:0]   cfg_index,
  input  logic [tbre_pkg::W_CFG-1:0]   cfg_data
);
  import tbre_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer over bits and edges
  tbre_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // timing arithmetic and output register
  tbre_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg_ready        (cfg_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level        (out_level),
    .out_sample_count (out_sample_count),
    .out_last         (out_last)
  );

endmodule

### rtl/tbre_checker.sv
`timescale 1ns / 1ps
`include "tape_byte_edge_run_encoder_defines.svh"

module tbre_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [tbre_pkg::W_OP-1:0]    in_op,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tbre_pkg::W_LEVEL-1:0] out_level,
  input logic [tbre_pkg::W_COUNT-1:0] out_sample_count,
  input logic                         out_last
);
  import tbre_pkg::*;

  // reset empties the output register
  `TBRE_ASSERT_RESET(a_reset_clears_out, !out_valid)

  // a stalled result transaction keeps its payload
  `TBRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_sample_count) && $stable(out_last))

  // sync is done in its accept cycle
  `TBRE_ASSERT_NEXT(a_sync_stays_ready, in_valid && in_ready && in_op == OP_SYNC, in_ready)

  // bytes and gaps hold off the next input transaction
  `TBRE_ASSERT_NEXT(a_work_blocks_input, in_valid && in_ready && (in_op == OP_BYTE || in_op == OP_MOTOR_ON || in_op == OP_MOTOR_OFF || in_op == OP_DATA_GAP), !in_ready)

endmodule

bind tape_byte_edge_run_encoder tbre_checker u_tbre_checker (.*);

### verif/tape_byte_edge_run_encoder_tb.sv
`timescale 1ns / 1ps

module tape_byte_edge_run_encoder_tb;

  // one input transaction
  typedef struct packed {
    logic [tbre_pkg::W_OP-1:0]   op;
    logic [tbre_pkg::W_BYTE-1:0] data;
  } tape_item_t;

  // one output run
  typedef struct packed {
    logic [tbre_pkg::W_LEVEL-1:0] level;
    logic [tbre_pkg::W_COUNT-1:0] count;
    logic                         last;
  } tape_run_t;

  // op codes the block ignores
  localparam logic [tbre_pkg::W_OP-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [tbre_pkg::W_OP-1:0] OP_SPARE_LAST  = 3'd7;

  // run timing: 19968 cpu cycles per 20 ms frame, scaled to one second
  localparam longint unsigned CYCLES_PER_SEC = 64'd19968 * 64'd1000000 / 64'd20000;
  localparam int unsigned     SHORT_WAIT     = 'h2d;
  localparam int unsigned     LONG_WAIT      = 'h32;
  localparam int unsigned     FAST_MID       = 269;
  localparam int unsigned     FAST_TAIL      = 564;
  localparam logic [17:0]     RATE_MAX       = 18'h3FFFF;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE      = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [tbre_pkg::W_OP-1:0]    in_op = '0;
  logic [tbre_pkg::W_BYTE-1:0]  in_data_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [tbre_pkg::W_LEVEL-1:0] out_level;
  logic [tbre_pkg::W_COUNT-1:0] out_sample_count;
  logic                         out_last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [tbre_pkg::W_IDX-1:0]   cfg_index = '0;
  logic [tbre_pkg::W_CFG-1:0]   cfg_data = '0;

  tape_byte_edge_run_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level        (out_level),
    .out_sample_count (out_sample_count),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tape_item_t pending_items[$];
  tape_run_t  expected_runs[$];
  tape_run_t  byte_runs[$];

  // encoder state mirror
  logic [7:0]  sig_level;
  logic [15:0] cyc_count;
  logic [19:0] frac_samples;
  logic [17:0] sample_rate;
  logic        fast_bits;

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int   items_taken = 0;
  int   errors = 0;
  int   idle_cycles = 0;

  function automatic void add_cycles(int unsigned c);
    cyc_count = cyc_count + 16'(c);
  endfunction

  // close one edge: emit the run at the current level, then flip
  function automatic void close_edge();
    longint unsigned t;
    tape_run_t r;
    t = 64'(cyc_count) * 64'(sample_rate) + 64'(frac_samples);
    r.level = sig_level;
    r.count = 19'(t / CYCLES_PER_SEC);
    r.last  = 1'b0;
    byte_runs.push_back(r);
    frac_samples = 20'(t % CYCLES_PER_SEC);
    sig_level = ~sig_level;
    cyc_count = '0;
  endfunction

  function automatic void gap_run(logic [18:0] cnt);
    tape_run_t r;
    r.level = sig_level;
    r.count = cnt;
    r.last  = 1'b0;
    byte_runs.push_back(r);
  endfunction

  // predict the runs caused by one item and queue them
  function automatic void predict_item(tape_item_t it);
    logic [7:0] m;
    byte_runs.delete();
    case (it.op)
      tbre_pkg::OP_BYTE: begin
        add_cycles(4 + 2 + 7);
        add_cycles(4 + 2);
        m = 8'h80;
        for (int i = 0; i < 8; i++) begin
          add_cycles(7 + 2 + 4 + 4);
          close_edge();
          if (!fast_bits) begin
            add_cycles(5 + 3 + 7 + SHORT_WAIT * 8 + 2 + 5 + 3 + 6 + 3);
            if ((it.data & m) == 0) begin
              add_cycles(7 + LONG_WAIT * 8 + 2 + 5);
            end else begin
              add_cycles(7 + 2 + 4 + 4);
              close_edge();
              add_cycles(5 + 4 + 1 + 7 + (LONG_WAIT - 3) * 8 + 2 + 5);
            end
          end else begin
            add_cycles(FAST_MID);
            if ((it.data & m) != 0) close_edge();
            add_cycles(FAST_TAIL);
          end
          add_cycles(2 + 3);
          m = m >> 1;
        end
        add_cycles(5);
        add_cycles(6 + 3);
      end
      tbre_pkg::OP_MOTOR_ON:  gap_run(19'(sample_rate));
      tbre_pkg::OP_MOTOR_OFF: gap_run(19'(64'(sample_rate) * 2));
      tbre_pkg::OP_DATA_GAP:  gap_run(19'(sample_rate / 8));
      tbre_pkg::OP_SYNC: begin
        cyc_count = '0;
        frac_samples = '0;
      end
      default: ;
    endcase
    if (byte_runs.size() > 0) byte_runs[byte_runs.size() - 1].last = 1'b1;
    foreach (byte_runs[i]) expected_runs.push_back(byte_runs[i]);
  endfunction

  // prediction, output check and handshake flags
  always @(posedge clk) begin
    tape_run_t want;
    if (!rst_n) begin
      sig_level    = tbre_pkg::LEVEL_RESET;
      cyc_count    = '0;
      frac_samples = '0;
      sample_rate  = tbre_pkg::RATE_RESET;
      fast_bits    = 1'b0;
      in_fire  <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tbre_pkg::REG_RATE) sample_rate = cfg_data[17:0];
        else fast_bits = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        predict_item('{op: in_op, data: in_data_byte});
        items_taken <= items_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected run: level %0d count %0d last %0d",
                 out_level, out_sample_count, out_last);
          errors++;
        end else begin
          want = expected_runs.pop_front();
          if (out_level !== want.level) begin
            $error("level mismatch: expected %0d actual %0d", want.level, out_level);
            errors++;
          end
          if (out_sample_count !== want.count) begin
            $error("sample_count mismatch: expected %0d actual %0d",
                   want.count, out_sample_count);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d actual %0d", want.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    tape_item_t it;
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_op        <= it.op;
        in_data_byte <= it.data;
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: random stall pattern plus occasional long hold-off
  int rx_mode = 0;
  int rx_span = 0;
  int hold_left = 0;
  int next_hold_at = 40;

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (items_taken >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at += 200;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(20, 200);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
    end
    out_ready <= rdy;
  end

  function automatic tape_item_t mk(logic [2:0] op, logic [7:0] data);
    tape_item_t it;
    it.op = op;
    it.data = data;
    return it;
  endfunction

  // mostly bytes, with gaps, syncs and ignored codes mixed in
  function automatic tape_item_t random_item();
    int r;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    if (r < 66) begin
      case ($urandom_range(0, 9))
        0: d = 8'h00;
        1: d = 8'hFF;
        default: ;
      endcase
      return mk(tbre_pkg::OP_BYTE, d);
    end
    if (r < 74) return mk(tbre_pkg::OP_MOTOR_ON, d);
    if (r < 80) return mk(tbre_pkg::OP_MOTOR_OFF, d);
    if (r < 88) return mk(tbre_pkg::OP_DATA_GAP, d);
    if (r < 94) return mk(tbre_pkg::OP_SYNC, d);
    return mk(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), d);
  endfunction

  // wait until the block has gone quiet
  task automatic drain();
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_runs.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic set_config(logic [17:0] rate, logic [17:0] mode_word);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= tbre_pkg::REG_RATE;
    cfg_data  <= rate;
    do @(negedge clk); while (!cfg_fire);
    cfg_index <= tbre_pkg::REG_MODE;
    cfg_data  <= mode_word;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [17:0] rate;
    logic [17:0] mode_word;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extremes, every op, sync before a byte
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h00));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'hFF));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h80));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h01));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'hA5));
    pending_items.push_back(mk(tbre_pkg::OP_MOTOR_ON, 8'hFF));
    pending_items.push_back(mk(tbre_pkg::OP_MOTOR_OFF, 8'h00));
    pending_items.push_back(mk(tbre_pkg::OP_DATA_GAP, 8'h5A));
    pending_items.push_back(mk(tbre_pkg::OP_SYNC, 8'hFF));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h5A));
    pending_items.push_back(mk(OP_SPARE_FIRST, 8'hFF));
    pending_items.push_back(mk(OP_SPARE_FIRST + 3'd1, 8'h00));
    pending_items.push_back(mk(OP_SPARE_LAST, 8'hFF));
    pending_items.push_back(mk(tbre_pkg::OP_SYNC, 8'h00));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h3C));
    drain();

    // directed: fastest rate with modified timing, upper bits of mode word set
    set_config(RATE_MAX, 18'h3FFFF);
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h00));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'hFF));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h81));
    pending_items.push_back(mk(tbre_pkg::OP_MOTOR_OFF, 8'h11));
    pending_items.push_back(mk(tbre_pkg::OP_DATA_GAP, 8'hEE));
    drain();

    // directed: zero rate gives empty runs
    set_config(18'd0, 18'd0);
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'hFF));
    pending_items.push_back(mk(tbre_pkg::OP_MOTOR_ON, 8'h00));
    pending_items.push_back(mk(tbre_pkg::OP_DATA_GAP, 8'h77));
    pending_items.push_back(mk(tbre_pkg::OP_BYTE, 8'h00));
    drain();

    // random phases, each under its own setting
    for (int ph = 0; ph < 8; ph++) begin
      case ((ph < 6) ? ph : $urandom_range(0, 5))
        0: rate = 18'd0;
        1: rate = RATE_MAX;
        2: rate = 18'd1000;
        3: rate = 18'd192000;
        4: rate = 18'($urandom_range(1000, 192000));
        default: rate = 18'($urandom());
      endcase
      mode_word = 18'($urandom());
      if (ph < 4) mode_word[0] = ph[0];
      set_config(rate, mode_word);
      for (int i = 0; i < 50; i++) pending_items.push_back(random_item());
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
